// ===== sv/thick_line_span_rasterizer_unit_macros.svh =====
`ifndef THICK_LINE_SPAN_RASTERIZER_UNIT_MACROS_SVH
`define THICK_LINE_SPAN_RASTERIZER_UNIT_MACROS_SVH

// check that cons holds in the same cycle as ante
`define TLSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlsr check failed");

// check that cons holds in the cycle after ante
`define TLSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlsr check failed");

`endif

// ===== sv/tlsr_pkg.sv =====
`default_nettype none

package tlsr_pkg;

  localparam int COORD_BITS    = 12;
  localparam int OUT_BITS      = 14;
  localparam int BW_BITS       = 7;
  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 48;
  localparam int DEF_MAX_WIDTH = 100;

  localparam logic OP_START = 1'b0;
  localparam logic OP_SPAN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_ROOT,
    ST_SPAN,
    ST_BLANK
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic root_step;
    logic emit_span;
    logic emit_blank;
  } cmd_t;

  typedef struct packed {
    logic line_active;
    logic held_round;
    logic root_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/thick_line_span_rasterizer_unit.sv =====
// Path from accept to result beat: start or idle request via ST_BLANK; square-brush span via
// ST_SPAN; round-brush span via ST_PROD, ST_ROOT and ST_SPAN, the bit-serial square root in
// ST_ROOT giving one root bit per cycle; HB = root bits (6 at MAX_WIDTH 100). The beat is
// registered as ST_SPAN or ST_BLANK is left; no new item is taken until it has been emitted.
// A waiting result beat does not block the next accept, only the emit of the next result beat.
// Reset (rst, synchronous, active high): no line loaded, width one, square brush, output empty.
`default_nettype none

`include "thick_line_span_rasterizer_unit_macros.svh"

module thick_line_span_rasterizer_unit #(
  parameter int MAX_WIDTH = tlsr_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36],
  // brush_width[54:48], round_brush[55]
  input  wire logic [tlsr_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // opcode[0]
  input  wire logic                                 s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // span_row[13:0], span_left[27:14], span_right[41:28], zero[47:42]
  output logic [tlsr_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
  // span_valid[0]
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tlast
);

  import tlsr_pkg::*;

  cmd_t    cmd;
  status_t status;

  tlsr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .opcode        (s_axis_tuser),
    .status        (status),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd)
  );

  tlsr_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_data       (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `TLSR_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `TLSR_ASSERT_SAME(a_span_needs_line, cmd.emit_span, status.line_active)
  `TLSR_ASSERT_SAME(a_root_only_round, cmd.root_step || cmd.prod, status.held_round)
  `TLSR_ASSERT_NEXT(a_emit_shows_beat, cmd.emit_span || cmd.emit_blank, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== sv/tlsr_ctrl.sv =====
`default_nettype none

module tlsr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  input  wire logic             opcode,
  input  wire tlsr_pkg::status_t status,
  output logic                  s_axis_tready,
  output tlsr_pkg::cmd_t        cmd
);

  import tlsr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (opcode == OP_START) begin
            cmd.load   = 1'b1;
            state_next = ST_BLANK;
          end else if (!status.line_active) begin
            state_next = ST_BLANK;
          end else if (status.held_round) begin
            state_next = ST_PROD;
          end else begin
            state_next = ST_SPAN;
          end
        end
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (status.out_free) begin
          cmd.emit_span = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_BLANK: begin
        if (status.out_free) begin
          cmd.emit_blank = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tlsr_dpath.sv =====
`default_nettype none

module tlsr_dpath #(
  parameter int MAX_WIDTH = tlsr_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tlsr_pkg::cmd_t                        cmd,
  input  wire logic [tlsr_pkg::IN_DATA_BITS-1:0]    in_data,
  input  wire logic                                 m_axis_tready,
  output tlsr_pkg::status_t                         status,
  output logic                                      m_axis_tvalid,
  output logic [tlsr_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
  output logic                                      m_axis_tuser,
  output logic                                      m_axis_tlast
);

  import tlsr_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = (WB > 1) ? WB - 1 : 1;
  localparam int RB = 2 * HB;
  localparam int CB = COORD_BITS;
  localparam int EB = CB + 3;
  localparam logic [BW_BITS-1:0] WMAX = BW_BITS'(MAX_WIDTH);

  logic [CB-1:0]        pos_x, pos_y, goal_x, goal_y, delta_x, delta_y;
  logic                 step_x_neg, step_y_neg;
  logic signed [CB+1:0] error_term;
  logic [WB-1:0]        row_offset;
  logic [WB-1:0]        held_width;
  logic                 held_round;
  logic                 line_active;
  logic [RB-1:0]        radicand;
  logic [HB-1:0]        root;
  logic [HB-1:0]        trial;

  logic [CB-1:0]        x1, y1, x2, y2, dx_load, dy_load;
  logic [BW_BITS-1:0]   bw_in, bw_sat;
  logic                 round_in;
  logic [HB-1:0]        half, hw, cand;
  logic [WB-1:0]        two_half;
  logic                 row_end, at_goal;
  logic [2*WB-1:0]      prod_full;
  logic [RB-1:0]        cand_sq;
  logic signed [EB-1:0] e2, dx_e, dy_e, err_wide;
  logic                 go_x, go_y;
  logic [OUT_BITS-1:0]  span_row, span_left, span_right;

  assign x1       = in_data[CB-1:0];
  assign y1       = in_data[2*CB-1:CB];
  assign x2       = in_data[3*CB-1:2*CB];
  assign y2       = in_data[4*CB-1:3*CB];
  assign bw_in    = in_data[4*CB+BW_BITS-1:4*CB];
  assign round_in = in_data[4*CB+BW_BITS];
  assign bw_sat   = (bw_in > WMAX) ? WMAX : bw_in;
  assign dx_load  = (x2 > x1) ? x2 - x1 : x1 - x2;
  assign dy_load  = (y2 > y1) ? y2 - y1 : y1 - y2;

  assign half     = HB'(held_width >> 1);
  assign two_half = WB'({1'b0, half} << 1);
  assign row_end  = row_offset >= two_half;
  assign at_goal  = (pos_x == goal_x) && (pos_y == goal_y);

  assign prod_full = {{WB{1'b0}}, row_offset} * {{WB{1'b0}}, WB'(two_half - row_offset)};
  assign cand      = root | trial;
  assign cand_sq   = {{HB{1'b0}}, cand} * {{HB{1'b0}}, cand};
  assign hw        = held_round ? root : half;

  assign span_row   = OUT_BITS'(pos_y) + OUT_BITS'(row_offset) - OUT_BITS'(half);
  assign span_left  = OUT_BITS'(pos_x) - OUT_BITS'(hw);
  assign span_right = OUT_BITS'(pos_x) + OUT_BITS'(hw);

  always_comb begin
    dx_e     = $signed(EB'(delta_x));
    dy_e     = $signed(EB'(delta_y));
    e2       = $signed({error_term, 1'b0});
    go_x     = e2 > -dy_e;
    go_y     = e2 < dx_e;
    err_wide = EB'(error_term);
    if (go_x) begin
      err_wide = err_wide - dy_e;
    end
    if (go_y) begin
      err_wide = err_wide + dx_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      row_offset  <= '0;
      held_width  <= WB'(1);
      held_round  <= 1'b0;
      line_active <= 1'b0;
    end else if (cmd.load) begin
      pos_x       <= x1;
      pos_y       <= y1;
      goal_x      <= x2;
      goal_y      <= y2;
      delta_x     <= dx_load;
      delta_y     <= dy_load;
      step_x_neg  <= !(x1 < x2);
      step_y_neg  <= !(y1 < y2);
      error_term  <= $signed({2'b00, dx_load}) - $signed({2'b00, dy_load});
      row_offset  <= '0;
      held_width  <= WB'(bw_sat);
      held_round  <= round_in;
      line_active <= 1'b1;
    end else if (cmd.emit_span) begin
      if (!row_end) begin
        row_offset <= row_offset + WB'(1);
      end else begin
        row_offset <= '0;
        if (at_goal) begin
          line_active <= 1'b0;
        end else begin
          error_term <= err_wide[CB+1:0];
          if (go_x) begin
            pos_x <= step_x_neg ? pos_x - CB'(1) : pos_x + CB'(1);
          end
          if (go_y) begin
            pos_y <= step_y_neg ? pos_y - CB'(1) : pos_y + CB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      radicand <= prod_full[RB-1:0];
      root     <= '0;
      trial    <= HB'(1) << (HB - 1);
    end else if (cmd.root_step) begin
      if (cand_sq <= radicand) begin
        root <= cand;
      end
      trial <= trial >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit_span || cmd.emit_blank) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_span) begin
      m_axis_tdata <= OUT_DATA_BITS'({span_right, span_left, span_row});
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= row_end && at_goal;
    end else if (cmd.emit_blank) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= 1'b0;
    end
  end

  assign status.line_active = line_active;
  assign status.held_round  = held_round;
  assign status.root_last   = trial[0];
  assign status.out_free    = !m_axis_tvalid || m_axis_tready;

endmodule

`default_nettype wire
